>>> rtl/tremor_confirmation_tracker_assert.svh
// assertion macros for the tremor confirmation tracker
`ifndef TREMOR_CONFIRMATION_TRACKER_ASSERT_SVH
`define TREMOR_CONFIRMATION_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define TCT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tct same-cycle check failed");
`define TCT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tct next-cycle check failed");
`else
`define TCT_ASSERT_IMP(label, clk, rst, ante, cons)
`define TCT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/tct_pkg.sv
// shared types and constants of the tremor confirmation tracker
package tct_pkg;

  localparam int RUN_COUNT_MAX_DEF = 255;

  localparam int CLASS_W    = 2;
  localparam int INT_W      = 12;
  localparam int LEVEL_W    = 10;
  localparam int STATUS_W   = 2;
  localparam int ALPHA_W    = 9;
  localparam int WIN_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int PROD_W     = 21;
  localparam int SUM_W      = 22;

  localparam logic [INT_W-1:0]   INTENSITY_MAX = 12'd3072;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE     = 9'd256;
  localparam logic [ALPHA_W-1:0] LEVEL_SCALE   = 9'd500;
  localparam logic [LEVEL_W-1:0] LEVEL_CAP     = 10'd1000;
  localparam logic [SUM_W-1:0]   EMA_ROUND     = 22'd128;

  localparam logic [ALPHA_W-1:0] ALPHA_RST   = 9'd77;
  localparam logic [WIN_W-1:0]   CONFIRM_RST = 8'd2;
  localparam logic [WIN_W-1:0]   CLEAR_RST   = 8'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR   = 2'd2;

  typedef enum logic [CLASS_W-1:0] {
    CLS_NONE   = 2'd0,
    CLS_TREMOR = 2'd1,
    CLS_DYSK   = 2'd2
  } class_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_NORMAL = 2'd0,
    STAT_TREMOR = 2'd1,
    STAT_DYSK   = 2'd2
  } status_t;

  typedef struct packed {
    logic accept;
    logic mul1;
    logic mul2;
    logic level;
  } tct_cmd_t;

  typedef struct packed {
    logic ema_active;
  } tct_sts_t;

endpackage

>>> rtl/tct_if.sv
// handshake channel interfaces of the tremor confirmation tracker
interface tct_in_if;
  logic                        valid;
  logic                        ready;
  logic [tct_pkg::CLASS_W-1:0] window_class;
  logic [tct_pkg::INT_W-1:0]   intensity;
  modport source (output valid, window_class, intensity, input ready);
  modport sink (input valid, window_class, intensity, output ready);
endinterface

interface tct_out_if;
  logic                         valid;
  logic                         ready;
  logic [tct_pkg::LEVEL_W-1:0]  tremor_level;
  logic [tct_pkg::LEVEL_W-1:0]  dysk_level;
  logic [tct_pkg::STATUS_W-1:0] status;
  modport source (output valid, tremor_level, dysk_level, status, input ready);
  modport sink (input valid, tremor_level, dysk_level, status, output ready);
endinterface

interface tct_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tct_pkg::CFG_IDX_W-1:0]  index;
  logic [tct_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/tremor_confirmation_tracker.sv
// top level of the tremor confirmation tracker
//
//  channel  | dir | payload                               | handshake
//  window   | in  | window_class, intensity               | valid / ready
//  result   | out | tremor_level, dysk_level, status      | valid / ready
//  cfg      | in  | index, data                           | valid / ready (always ready)
//
// result valid rises once a tremor or dyskinesia item has passed the MUL1, MUL2 and
// LEVEL states, or MUL1 and LEVEL for a none item; the shared ema multiply runs in
// MUL1 and MUL2, the level scaling in LEVEL. one item at a time: window ready
// returns the cycle after the result is taken.
// rst is synchronous, active high; it restores the register defaults and clears
// runs, averages and levels. a stalled result holds its value until taken.
`include "tremor_confirmation_tracker_assert.svh"

module tremor_confirmation_tracker #(
  parameter int RUN_COUNT_MAX = tct_pkg::RUN_COUNT_MAX_DEF
) (
  input logic       clk,
  input logic       rst,
  tct_in_if.sink    window,
  tct_out_if.source result,
  tct_cfg_if.sink   cfg
);

  tct_pkg::tct_cmd_t cmd;
  tct_pkg::tct_sts_t sts;

  assign cfg.ready = 1'b1;

  tct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (window.valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (window.ready),
    .out_valid (result.valid)
  );

  tct_dp #(
    .RUN_COUNT_MAX (RUN_COUNT_MAX)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .window_class  (window.window_class),
    .intensity     (window.intensity),
    .cfg_write     (cfg.valid && cfg.ready),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .tremor_level  (result.tremor_level),
    .dysk_level    (result.dysk_level),
    .status        (result.status)
  );

  // never taking a new item while a result is pending
  `TCT_ASSERT_IMP(a_ready_excl, clk, rst, result.valid, !window.ready)
  `TCT_ASSERT_NXT(a_accept_busy, clk, rst, window.valid && window.ready, !window.ready)
  `TCT_ASSERT_IMP(a_status_tremor, clk, rst, result.valid, (result.tremor_level != '0) == (result.status == tct_pkg::STAT_TREMOR))
  `TCT_ASSERT_IMP(a_level_cap, clk, rst, result.valid, (result.tremor_level <= tct_pkg::LEVEL_CAP) && (result.dysk_level <= tct_pkg::LEVEL_CAP))

endmodule

>>> rtl/tct_ctrl.sv
// sequencing state machine of the tremor confirmation tracker
module tct_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_ready,
  input  tct_pkg::tct_sts_t sts,
  output tct_pkg::tct_cmd_t cmd,
  output logic              in_ready,
  output logic              out_valid
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_LEVEL,
    S_OUT
  } state_t;

  state_t state;

  always_comb begin
    cmd = '0;
    cmd.accept = in_valid && in_ready;
    unique case (state)
      S_MUL1:  cmd.mul1  = 1'b1;
      S_MUL2:  cmd.mul2  = 1'b1;
      S_LEVEL: cmd.level = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= S_MUL1;
            in_ready <= 1'b0;
          end
        end
        S_MUL1: begin
          // none windows skip the average update in S_MUL2
          state <= sts.ema_active ? S_MUL2 : S_LEVEL;
        end
        S_MUL2: begin
          state <= S_LEVEL;
        end
        S_LEVEL: begin
          state     <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: begin
          if (out_ready) begin
            state     <= S_IDLE;
            out_valid <= 1'b0;
            in_ready  <= 1'b1;
          end
        end
        default: begin
          state     <= S_IDLE;
          in_ready  <= 1'b1;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

>>> rtl/tct_dp.sv
// datapath: config registers, run counters, averages and levels
module tct_dp #(
  parameter int RUN_COUNT_MAX = tct_pkg::RUN_COUNT_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tct_pkg::tct_cmd_t              cmd,
  output tct_pkg::tct_sts_t              sts,
  input  logic [tct_pkg::CLASS_W-1:0]    window_class,
  input  logic [tct_pkg::INT_W-1:0]      intensity,
  input  logic                           cfg_write,
  input  logic [tct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tct_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [tct_pkg::LEVEL_W-1:0]    tremor_level,
  output logic [tct_pkg::LEVEL_W-1:0]    dysk_level,
  output logic [tct_pkg::STATUS_W-1:0]   status
);

  localparam int RW = $clog2(RUN_COUNT_MAX + 1);
  localparam int CW = (RW > tct_pkg::WIN_W) ? RW : tct_pkg::WIN_W;
  localparam logic [RW-1:0] RUN_MAX = RW'(RUN_COUNT_MAX);

  logic [tct_pkg::ALPHA_W-1:0] alpha;
  logic [tct_pkg::WIN_W-1:0]   confirm_windows;
  logic [tct_pkg::WIN_W-1:0]   clear_windows;

  logic [tct_pkg::CLASS_W-1:0] cls_q;
  logic [tct_pkg::INT_W-1:0]   raw_q;
  logic [tct_pkg::PROD_W-1:0]  prod;

  logic [RW-1:0] tremor_run;
  logic [RW-1:0] dysk_run;
  logic [RW-1:0] quiet_run;

  logic [tct_pkg::INT_W-1:0]   tremor_avg;
  logic [tct_pkg::INT_W-1:0]   dysk_avg;
  logic [tct_pkg::LEVEL_W-1:0] tremor_level_next;
  logic [tct_pkg::LEVEL_W-1:0] dysk_level_next;

  logic [tct_pkg::ALPHA_W-1:0] alpha_sat;
  logic [tct_pkg::ALPHA_W-1:0] alpha_inv;
  logic [tct_pkg::INT_W-1:0]   avg_sel;
  logic [tct_pkg::SUM_W-1:0]   ema_sum;
  logic [tct_pkg::INT_W-1:0]   ema_new;
  logic [tct_pkg::WIN_W-1:0]   conf_eff;
  logic [tct_pkg::WIN_W-1:0]   clr_eff;
  logic                        hit_tremor;
  logic                        hit_dysk;
  logic                        hit_quiet;
  logic [tct_pkg::INT_W-1:0]   level_src;
  logic [tct_pkg::PROD_W-1:0]  level_prod;
  logic [tct_pkg::LEVEL_W:0]   level_raw;
  logic [tct_pkg::LEVEL_W-1:0] level_val;
  logic [tct_pkg::INT_W-1:0]   raw_sat;

  assign sts.ema_active = (cls_q == tct_pkg::CLS_TREMOR) || (cls_q == tct_pkg::CLS_DYSK);

  assign alpha_sat = (alpha > tct_pkg::ALPHA_ONE) ? tct_pkg::ALPHA_ONE : alpha;
  assign alpha_inv = tct_pkg::ALPHA_ONE - alpha_sat;
  assign avg_sel   = (cls_q == tct_pkg::CLS_TREMOR) ? tremor_avg : dysk_avg;
  assign raw_sat   = (intensity > tct_pkg::INTENSITY_MAX) ? tct_pkg::INTENSITY_MAX
                                                          : intensity;

  // second half of the average: old weight times old average, plus rounding
  assign ema_sum = tct_pkg::SUM_W'(prod)
                 + tct_pkg::SUM_W'(tct_pkg::PROD_W'(alpha_inv) * tct_pkg::PROD_W'(avg_sel))
                 + tct_pkg::EMA_ROUND;
  assign ema_new = ema_sum[tct_pkg::INT_W+7:8];

  assign conf_eff   = (confirm_windows == '0) ? tct_pkg::WIN_W'(1) : confirm_windows;
  assign clr_eff    = (clear_windows == '0) ? tct_pkg::WIN_W'(1) : clear_windows;
  assign hit_tremor = CW'(tremor_run) >= CW'(conf_eff);
  assign hit_dysk   = CW'(dysk_run) >= CW'(conf_eff);
  assign hit_quiet  = CW'(quiet_run) >= CW'(clr_eff);

  assign level_src  = hit_tremor ? tremor_avg : dysk_avg;
  assign level_prod = tct_pkg::PROD_W'(level_src) * tct_pkg::PROD_W'(tct_pkg::LEVEL_SCALE);
  assign level_raw  = level_prod[tct_pkg::PROD_W-1:10];
  assign level_val  = (level_raw > (tct_pkg::LEVEL_W+1)'(tct_pkg::LEVEL_CAP))
                    ? tct_pkg::LEVEL_CAP : level_raw[tct_pkg::LEVEL_W-1:0];

  always_comb begin
    tremor_level_next = tremor_level;
    dysk_level_next   = dysk_level;
    priority if (hit_tremor) begin
      tremor_level_next = level_val;
      dysk_level_next   = '0;
    end else if (hit_dysk) begin
      dysk_level_next   = level_val;
      tremor_level_next = '0;
    end else if (hit_quiet) begin
      tremor_level_next = '0;
      dysk_level_next   = '0;
    end else begin
      tremor_level_next = tremor_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha           <= tct_pkg::ALPHA_RST;
      confirm_windows <= tct_pkg::CONFIRM_RST;
      clear_windows   <= tct_pkg::CLEAR_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tct_pkg::REG_ALPHA:   alpha           <= cfg_data;
        tct_pkg::REG_CONFIRM: confirm_windows <= cfg_data[tct_pkg::WIN_W-1:0];
        tct_pkg::REG_CLEAR:   clear_windows   <= cfg_data[tct_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cls_q <= window_class;
      raw_q <= raw_sat;
    end
    if (cmd.mul1) begin
      prod <= tct_pkg::PROD_W'(alpha_sat) * tct_pkg::PROD_W'(raw_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tremor_run   <= '0;
      dysk_run     <= '0;
      quiet_run    <= '0;
      tremor_avg   <= '0;
      dysk_avg     <= '0;
      tremor_level <= '0;
      dysk_level   <= '0;
      status       <= tct_pkg::STAT_NORMAL;
    end else begin
      if (cmd.accept) begin
        unique case (window_class)
          tct_pkg::CLS_TREMOR: begin
            tremor_run <= (tremor_run >= RUN_MAX) ? RUN_MAX : tremor_run + RW'(1);
            dysk_run   <= '0;
            quiet_run  <= '0;
          end
          tct_pkg::CLS_DYSK: begin
            dysk_run   <= (dysk_run >= RUN_MAX) ? RUN_MAX : dysk_run + RW'(1);
            tremor_run <= '0;
            quiet_run  <= '0;
          end
          // unused class code counts as none
          default: begin
            quiet_run  <= (quiet_run >= RUN_MAX) ? RUN_MAX : quiet_run + RW'(1);
            tremor_run <= '0;
            dysk_run   <= '0;
          end
        endcase
      end
      if (cmd.mul2) begin
        if (cls_q == tct_pkg::CLS_TREMOR) begin
          tremor_avg <= ema_new;
        end else begin
          dysk_avg <= ema_new;
        end
      end
      if (cmd.level) begin
        tremor_level <= tremor_level_next;
        dysk_level   <= dysk_level_next;
        if (!hit_tremor && !hit_dysk && hit_quiet) begin
          tremor_avg <= '0;
          dysk_avg   <= '0;
        end
        if (tremor_level_next != '0) begin
          status <= tct_pkg::STAT_TREMOR;
        end else if (dysk_level_next != '0) begin
          status <= tct_pkg::STAT_DYSK;
        end else begin
          status <= tct_pkg::STAT_NORMAL;
        end
      end
    end
  end

endmodule
